// File: src/lzss_stream_decompressor_unit_assert.svh
// assertion macros for the lzss stream decompressor unit
// depends on clock and reset signals named clock and reset in the using module
`ifndef LZSS_STREAM_DECOMPRESSOR_UNIT_ASSERT_SVH
`define LZSS_STREAM_DECOMPRESSOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define LSDU_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lsdu assertion failed");
`define LSDU_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lsdu assertion failed");
`else
`define LSDU_ASSERT_IMPLY(lbl, ante, cons)
`define LSDU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/lsdu_pkg.sv
// shared types and constants for the lzss stream decompressor unit
// no dependencies
`default_nettype none
package lsdu_pkg;
   localparam int WINDOW_DEPTH = 4096;
   localparam int POS_W = $clog2(WINDOW_DEPTH);
   localparam int LIMIT_W = 23;
   localparam int CNT_W = 5;
   localparam logic [POS_W-1:0] START_POS = 12'hfee;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 23'd4194304;
   localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;
   localparam logic [CNT_W-1:0] MIN_MATCH_M1 = 5'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COPY
   } state_type;
endpackage
`default_nettype wire

// File: src/lzss_stream_decompressor_unit.sv
// lzss decoder with a 4096-byte history window held in one synchronous ram
// depends on lsdu_pkg and lzss_stream_decompressor_unit_assert.svh
// output: a literal's item appears the cycle after its input item is accepted;
//   a match's bytes pass the ram read register, then the output register,
//   one byte a cycle while rsp_stall is low; one flag, literal or first match
//   byte a cycle if output is free; a second match byte stalls input for its copy
// reset: a pass over every address clears the window to zero, input stalled meanwhile
`default_nettype none
`include "lzss_stream_decompressor_unit_assert.svh"
module lzss_stream_decompressor_unit
   import lsdu_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_in_byte,
   input  wire logic               req_stream_end,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_run_last,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [LIMIT_W-1:0] csr_output_limit
);

   state_type state_ff, state_in;

   logic [POS_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [POS_W-1:0]   wpos_ff, wpos_in;
   logic [POS_W-1:0]   src_ff, src_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               end_ff, end_in;
   logic [7:0]         flag_bits_ff, flag_bits_in;
   logic [3:0]         flags_left_ff, flags_left_in;
   logic [7:0]         pend_low_ff, pend_low_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [LIMIT_W-1:0] emitted_ff, emitted_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_byte_ff, out_byte_in;
   logic               out_last_ff, out_last_in;

   // window ram
   logic [7:0]       window_mem [WINDOW_DEPTH];
   logic [7:0]       mem_q_ff;
   logic             hit_ff;
   logic [7:0]       fwd_ff;
   logic             rd_en, wr_en;
   logic [POS_W-1:0] rd_addr, wr_addr;
   logic [7:0]       wr_data;

   logic             out_free, accept, clear_done;
   logic             put_en, put_final, emit;
   logic [7:0]       put_data, copy_byte;
   logic [POS_W-1:0] match_src;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign accept     = req_valid && !req_stall;
   assign clear_done = (clr_addr_ff == POS_W'(WINDOW_DEPTH - 1));
   assign copy_byte  = hit_ff ? fwd_ff : mem_q_ff;
   assign match_src  = {req_in_byte[7:4], pend_low_ff};
   assign emit       = put_en && (emitted_ff < limit_ff);

   assign req_stall    = (state_ff != ST_IDLE) || !out_free;
   assign csr_ready    = 1'b1;
   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_run_last = out_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && pend_valid_ff) state_in = ST_COPY;
         end
         ST_COPY: begin
            if (out_free && cnt_ff == '0) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath and ram control
   always_comb begin
      clr_addr_in   = clr_addr_ff;
      wpos_in       = wpos_ff;
      src_in        = src_ff;
      cnt_in        = cnt_ff;
      end_in        = end_ff;
      flag_bits_in  = flag_bits_ff;
      flags_left_in = flags_left_ff;
      pend_low_in   = pend_low_ff;
      pend_valid_in = pend_valid_ff;
      emitted_in    = emitted_ff;
      limit_in      = (csr_valid && csr_ready) ? csr_output_limit : limit_ff;
      rd_en         = 1'b0;
      rd_addr       = src_ff;
      wr_en         = 1'b0;
      wr_addr       = wpos_ff;
      wr_data       = 8'h00;
      put_en        = 1'b0;
      put_final     = 1'b1;
      put_data      = req_in_byte;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               priority if (pend_valid_ff) begin
                  pend_valid_in = 1'b0;
                  rd_en         = 1'b1;
                  rd_addr       = match_src;
                  src_in        = match_src + 1'b1;
                  cnt_in        = {1'b0, req_in_byte[3:0]} + MIN_MATCH_M1;
                  end_in        = req_stream_end;
               end else if (flags_left_ff == '0) begin
                  flag_bits_in  = req_in_byte;
                  flags_left_in = FLAGS_PER_BYTE;
               end else begin
                  flag_bits_in  = flag_bits_ff >> 1;
                  flags_left_in = flags_left_ff - 1'b1;
                  if (flag_bits_ff[0]) begin
                     put_en = 1'b1;
                  end else begin
                     pend_low_in   = req_in_byte;
                     pend_valid_in = 1'b1;
                  end
               end
            end
         end
         ST_COPY: begin
            if (out_free) begin
               put_en    = 1'b1;
               put_data  = copy_byte;
               put_final = (cnt_ff == '0);
               if (cnt_ff != '0) begin
                  rd_en   = 1'b1;
                  rd_addr = src_ff;
                  src_in  = src_ff + 1'b1;
                  cnt_in  = cnt_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      if (put_en) begin
         wr_en   = 1'b1;
         wr_addr = wpos_ff;
         wr_data = put_data;
         wpos_in = wpos_ff + 1'b1;
      end
      if (emit) emitted_in = emitted_ff + 1'b1;

      // end of stream: at once, or after the copy it started
      if ((state_ff == ST_IDLE && accept && !pend_valid_ff && req_stream_end) ||
          (state_ff == ST_COPY && out_free && cnt_ff == '0 && end_ff)) begin
         wpos_in       = START_POS;
         flag_bits_in  = '0;
         flags_left_in = '0;
         pend_low_in   = '0;
         pend_valid_in = 1'b0;
         emitted_in    = '0;
      end
   end

   // output item register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (out_free) begin
         out_valid_in = emit;
         out_byte_in  = put_data;
         // last item also when the limit cuts the run short
         out_last_in  = put_final || (LIMIT_W'(emitted_ff + 1'b1) == limit_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) window_mem[wr_addr] <= wr_data;
      if (rd_en) begin
         mem_q_ff <= window_mem[rd_addr];
         hit_ff   <= wr_en && (wr_addr == rd_addr);
         fwd_ff   <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         wpos_ff       <= START_POS;
         cnt_ff        <= '0;
         end_ff        <= 1'b0;
         flag_bits_ff  <= '0;
         flags_left_ff <= '0;
         pend_low_ff   <= '0;
         pend_valid_ff <= 1'b0;
         emitted_ff    <= '0;
         limit_ff      <= LIMIT_RESET;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         wpos_ff       <= wpos_in;
         cnt_ff        <= cnt_in;
         end_ff        <= end_in;
         flag_bits_ff  <= flag_bits_in;
         flags_left_ff <= flags_left_in;
         pend_low_ff   <= pend_low_in;
         pend_valid_ff <= pend_valid_in;
         emitted_ff    <= emitted_in;
         limit_ff      <= limit_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   `LSDU_ASSERT_IMPLY(a_busy_stalls, state_ff != ST_IDLE, req_stall)
   `LSDU_ASSERT_IMPLY(a_quiet_during_clear, state_ff == ST_CLEAR, !out_valid_ff)
   `LSDU_ASSERT_NEXT(a_copy_continues, state_ff == ST_COPY && out_free && cnt_ff != '0,
      state_ff == ST_COPY)

endmodule
`default_nettype wire

// File: test/tb.sv
// self-checking testbench for lzss_stream_decompressor_unit: directed rows, then random streams
// over several output limits, each result checked against a row's expected bytes or a built-in lzss decoder
// depends on lsdu_pkg and the unit under test
`timescale 1ns / 100ps
module tb;
   import lsdu_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int PHASE_ITEMS = 40;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_LIMIT_PHASE = 4;
   localparam int NUM_PHASES = 6;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } dec_item_type;

   typedef struct packed {
      logic [7:0] code;
      logic       eos;
   } in_item_type;

   typedef struct packed {
      logic [7:0] code;
      logic       eos;
      logic       typed;
      logic [4:0] n;
      logic [7:0] val;
   } step_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic req_stream_end = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic rsp_run_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [LIMIT_W-1:0] csr_output_limit = LIMIT_RESET;

   always #5 clock = ~clock;

   lzss_stream_decompressor_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_in_byte(req_in_byte),
      .req_stream_end(req_stream_end),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_run_last(rsp_run_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_output_limit(csr_output_limit)
   );

   // decoder state
   logic [7:0] hist [0:WINDOW_DEPTH-1];
   logic [POS_W-1:0] put_pos;
   logic [7:0] flag_reg;
   logic [3:0] flag_cnt;
   logic [7:0] held_lo;
   logic held;
   logic [LIMIT_W-1:0] emit_cnt;
   logic [LIMIT_W-1:0] emit_max;
   dec_item_type run_q[$];
   dec_item_type want_q[$];
   in_item_type stream_q[$];

   int errors = 0;
   int idle_cycles = 0;
   bit calm = 1'b0;
   int sink_hold = 0;
   dec_item_type got_w;

   step_row_type directed_rows [22] = '{
      '{8'h0f, 1'b0, 1'b1, 5'd0, 8'h00},
      '{8'h00, 1'b0, 1'b1, 5'd1, 8'h00},
      '{8'hff, 1'b0, 1'b1, 5'd1, 8'hff},
      '{8'h80, 1'b0, 1'b1, 5'd1, 8'h80},
      '{8'h01, 1'b0, 1'b1, 5'd1, 8'h01},
      '{8'hee, 1'b0, 1'b1, 5'd0, 8'h00},
      '{8'hf0, 1'b0, 1'b0, 5'd0, 8'h00},
      '{8'hf3, 1'b0, 1'b1, 5'd0, 8'h00},
      '{8'hff, 1'b0, 1'b0, 5'd0, 8'h00},   // overlapping copy, length 18
      '{8'hff, 1'b0, 1'b1, 5'd0, 8'h00},
      '{8'hff, 1'b0, 1'b0, 5'd0, 8'h00},   // copy wraps the window end
      '{8'h00, 1'b0, 1'b1, 5'd0, 8'h00},
      '{8'h00, 1'b1, 1'b0, 5'd0, 8'h00},
      '{8'h00, 1'b1, 1'b1, 5'd0, 8'h00},   // end on a flag byte
      '{8'h00, 1'b0, 1'b1, 5'd0, 8'h00},
      '{8'h55, 1'b1, 1'b1, 5'd0, 8'h00},   // end drops a half-read match
      '{8'h01, 1'b0, 1'b1, 5'd0, 8'h00},
      '{8'h7e, 1'b1, 1'b1, 5'd1, 8'h7e},
      '{8'h00, 1'b0, 1'b1, 5'd0, 8'h00},
      '{8'h34, 1'b0, 1'b1, 5'd0, 8'h00},
      '{8'h12, 1'b0, 1'b0, 5'd0, 8'h00},
      '{8'h9a, 1'b1, 1'b1, 5'd0, 8'h00}
   };

   logic [LIMIT_W-1:0] phase_limits [NUM_PHASES] = '{
      23'h7fffff, 23'd0, 23'd1, 23'd9, 23'd0, LIMIT_RESET
   };

   task automatic restart_stream();
      put_pos = START_POS;
      flag_reg = 8'h00;
      flag_cnt = 4'd0;
      held_lo = 8'h00;
      held = 1'b0;
      emit_cnt = '0;
   endtask

   task automatic put_out(input logic [7:0] b);
      dec_item_type t;
      hist[put_pos] = b;
      put_pos = put_pos + 1'b1;
      if (emit_cnt < emit_max) begin
         emit_cnt = emit_cnt + 1'b1;
         t.data = b;
         t.last = 1'b0;
         run_q.push_back(t);
      end
   endtask

   // decodes one compressed byte into run_q
   task automatic decode_item(input in_item_type it);
      logic [POS_W-1:0] src;
      int n;
      dec_item_type t;
      run_q.delete();
      if (held) begin
         src = {it.code[7:4], held_lo};
         n = int'(it.code[3:0]) + 3;
         held = 1'b0;
         for (int i = 0; i < n; i++) begin
            put_out(hist[src]);
            src = src + 1'b1;
         end
      end else if (flag_cnt == 4'd0) begin
         flag_reg = it.code;
         flag_cnt = FLAGS_PER_BYTE;
      end else begin
         flag_cnt = flag_cnt - 1'b1;
         if (flag_reg[0]) begin
            put_out(it.code);
         end else begin
            held_lo = it.code;
            held = 1'b1;
         end
         flag_reg = flag_reg >> 1;
      end
      if (run_q.size() > 0) begin
         t = run_q.pop_back();
         t.last = 1'b1;
         run_q.push_back(t);
      end
      if (it.eos) restart_stream();
   endtask

   task automatic send_item(input in_item_type it, input logic typed, input int n,
                            input logic [7:0] val);
      int gap;
      dec_item_type t;
      @(negedge clock);
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= it.code;
      req_stream_end <= it.eos;
      do @(posedge clock); while (req_stall);
      decode_item(it);
      if (typed) begin
         for (int i = 0; i < n; i++) begin
            t.data = val;
            t.last = (i == n - 1);
            want_q.push_back(t);
         end
      end else begin
         foreach (run_q[i]) want_q.push_back(run_q[i]);
      end
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (want_q.size() > 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] v);
      wait_drain();
      // a match past the limit keeps the unit busy with no item to show for it
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_output_limit <= v;
      do @(posedge clock); while (!csr_ready);
      emit_max = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic push_code(input logic [7:0] b);
      in_item_type it;
      it.code = b;
      it.eos = 1'b0;
      stream_q.push_back(it);
   endtask

   // one stream: random bytes now and then, else flag groups whose matches mostly point just behind the write position
   task automatic build_stream();
      logic [7:0] flags;
      logic [POS_W-1:0] gpos;
      logic [POS_W-1:0] off;
      logic [3:0] lc;
      int groups;
      int cut;
      in_item_type it;
      stream_q.delete();
      if ($urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 12)) push_code(8'($urandom));
      end else begin
         gpos = START_POS;
         groups = $urandom_range(1, 3);
         for (int g = 0; g < groups; g++) begin
            flags = 8'($urandom);
            push_code(flags);
            for (int k = 0; k < 8; k++) begin
               if (flags[k]) begin
                  push_code(8'($urandom));
                  gpos = gpos + 1'b1;
               end else begin
                  lc = 4'($urandom);
                  if ($urandom_range(0, 3) == 0) off = POS_W'($urandom);
                  else off = gpos - POS_W'($urandom_range(1, 24));
                  push_code(off[7:0]);
                  push_code({off[11:8], lc});
                  gpos = gpos + POS_W'(lc) + POS_W'(3);
               end
            end
         end
         // a broken stream now and then
         if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, stream_q.size());
            while (stream_q.size() > cut) void'(stream_q.pop_back());
         end
      end
      it = stream_q.pop_back();
      it.eos = 1'b1;
      stream_q.push_back(it);
   endtask

   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else if (sink_hold > 0) begin
         sink_hold <= sink_hold - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         sink_hold <= $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (want_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none, got byte %02h last %0b",
                     $time, rsp_out_byte, rsp_run_last);
         end else begin
            got_w = want_q.pop_front();
            if (rsp_out_byte !== got_w.data) begin
               errors++;
               $display("%0t: out_byte mismatch, expected %02h, got %02h",
                        $time, got_w.data, rsp_out_byte);
            end
            if (rsp_run_last !== got_w.last) begin
               errors++;
               $display("%0t: run_last mismatch, expected %0b, got %0b",
                        $time, got_w.last, rsp_run_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      logic [LIMIT_W-1:0] lim;
      int sent;
      in_item_type it;
      for (int i = 0; i < WINDOW_DEPTH; i++) hist[i] = 8'h00;
      restart_stream();
      emit_max = LIMIT_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         it.code = directed_rows[i].code;
         it.eos = directed_rows[i].eos;
         send_item(it, directed_rows[i].typed, int'(directed_rows[i].n),
                   directed_rows[i].val);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         lim = (p == RANDOM_LIMIT_PHASE) ? LIMIT_W'($urandom_range(2, 40)) : phase_limits[p];
         write_limit(lim);
         calm = (p == NUM_PHASES - 1);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            build_stream();
            if (!calm && $urandom_range(0, 7) == 0) wait_drain();
            foreach (stream_q[i]) send_item(stream_q[i], 1'b0, 0, 8'h00);
            sent += stream_q.size();
         end
      end

      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
